>>> rtl/core/tbp_pkg.sv
package tbp_pkg;

  localparam int MAX_NODES = 2048;
  localparam int NODE_LIM  = (MAX_NODES / 2 > 1024) ? 1024 : MAX_NODES / 2;

  localparam logic [2:0] CFG_START_VALUE    = 3'd0;
  localparam logic [2:0] CFG_SPACING_NOW    = 3'd1;
  localparam logic [2:0] CFG_SPACING_NEXT   = 3'd2;
  localparam logic [2:0] CFG_RECIP_SPACING  = 3'd3;
  localparam logic [2:0] CFG_DECAY_STEP     = 3'd4;
  localparam logic [2:0] CFG_VARIANCE_RATIO = 3'd5;

  localparam logic signed [11:0] RANGE_LOW_INIT  = 12'sd2047;
  localparam logic signed [11:0] RANGE_HIGH_INIT = -12'sd2048;

  localparam logic signed [47:0] SAT_HI = 48'sd2147483647;
  localparam logic signed [47:0] SAT_LO = -48'sd2147483648;
  localparam logic signed [63:0] HALF24 = 64'sd8388608;
  localparam logic signed [47:0] ONE24  = 48'sd16777216;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_JDX,
    OP_X,
    OP_MUL_DRIFT,
    OP_DRIFT,
    OP_OFF,
    OP_MUL_P,
    OP_ABS,
    OP_K,
    OP_MUL_KD,
    OP_ETA,
    OP_MUL_ETA,
    OP_E,
    OP_MUL_SQ,
    OP_A
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/trinomial_branch_probabilities_core.sv
// Trinomial branching core: takes one node index at a time and returns its
// rounded next-slice centre, the up/middle/down probabilities (Q1.30) and the
// running next-slice node range, which is complete on the node marked last.
// One item is in flight at a time; a result becomes valid once its item has
// passed the computation steps and the result step, which waits while the
// output register is full; the next item can be accepted in the first cycle
// that the result is valid. Each item makes six passes through the single shared
// 32x32 multiplier, each followed by a rounding or saturation step. Configuration
// writes take effect at once and must be made while no item is in flight.
module trinomial_branch_probabilities_core import tbp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [10:0]  node_index,
  input  logic                last_node,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [10:0]  branch_centre,
  output logic signed [31:0]  prob_up,
  output logic signed [31:0]  prob_mid,
  output logic signed [31:0]  prob_down,
  output logic signed [11:0]  next_min,
  output logic signed [11:0]  next_max,
  output logic                range_final
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tbp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .node_index    (node_index),
    .last_node     (last_node),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .branch_centre (branch_centre),
    .prob_up       (prob_up),
    .prob_mid      (prob_mid),
    .prob_down     (prob_down),
    .next_min      (next_min),
    .next_max      (next_max),
    .range_final   (range_final)
  );

endmodule

>>> rtl/core/tbp_ctrl.sv
module tbp_ctrl import tbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_JDX,
    S_X,
    S_MUL_DRIFT,
    S_DRIFT,
    S_OFF,
    S_MUL_P,
    S_ABS,
    S_K,
    S_MUL_KD,
    S_ETA,
    S_MUL_ETA,
    S_E,
    S_MUL_SQ,
    S_A,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.emit   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op     = OP_LOAD;
          state_next = S_MUL_JDX;
        end
      end
      S_MUL_JDX: begin
        cmd.op     = OP_MUL_JDX;
        state_next = S_X;
      end
      S_X: begin
        cmd.op     = OP_X;
        state_next = S_MUL_DRIFT;
      end
      S_MUL_DRIFT: begin
        cmd.op     = OP_MUL_DRIFT;
        state_next = S_DRIFT;
      end
      S_DRIFT: begin
        cmd.op     = OP_DRIFT;
        state_next = S_OFF;
      end
      S_OFF: begin
        cmd.op     = OP_OFF;
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.op     = OP_MUL_P;
        state_next = S_ABS;
      end
      S_ABS: begin
        cmd.op     = OP_ABS;
        state_next = S_K;
      end
      S_K: begin
        cmd.op     = OP_K;
        state_next = S_MUL_KD;
      end
      S_MUL_KD: begin
        cmd.op     = OP_MUL_KD;
        state_next = S_ETA;
      end
      S_ETA: begin
        cmd.op     = OP_ETA;
        state_next = S_MUL_ETA;
      end
      S_MUL_ETA: begin
        cmd.op     = OP_MUL_ETA;
        state_next = S_E;
      end
      S_E: begin
        cmd.op     = OP_E;
        state_next = S_MUL_SQ;
      end
      S_MUL_SQ: begin
        cmd.op     = OP_MUL_SQ;
        state_next = S_A;
      end
      S_A: begin
        cmd.op     = OP_A;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !status.out_free) |=> (state == S_OUT))
    else $error("result step left while output register is full");

endmodule

>>> rtl/core/tbp_datapath.sv
module tbp_datapath import tbp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [10:0]  node_index,
  input  logic                last_node,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [10:0]  branch_centre,
  output logic signed [31:0]  prob_up,
  output logic signed [31:0]  prob_mid,
  output logic signed [31:0]  prob_down,
  output logic signed [11:0]  next_min,
  output logic signed [11:0]  next_max,
  output logic                range_final
);

  logic signed [31:0] start_value;
  logic        [30:0] spacing_now;
  logic        [30:0] spacing_next;
  logic        [30:0] recip_spacing_next;
  logic signed [31:0] decay_step;
  logic        [30:0] variance_ratio;

  logic signed [11:0] range_low;
  logic signed [11:0] range_high;

  logic signed [10:0] node_j;
  logic               last_reg;
  logic signed [63:0] prod;
  logic signed [41:0] jdx;
  logic signed [31:0] xs;
  logic signed [39:0] drift;
  logic signed [31:0] off;
  logic               p_neg;
  logic        [63:0] mag;
  logic signed [10:0] k;
  logic signed [31:0] eta;
  logic signed [31:0] e;
  logic signed [40:0] a;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] rnd_sum;
  logic        [16:0] kmag;
  logic signed [11:0] k_lo;
  logic signed [11:0] k_hi;
  logic signed [11:0] low_new;
  logic signed [11:0] high_new;
  logic signed [47:0] s_up;
  logic signed [47:0] s_mid;
  logic signed [47:0] s_down;

  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_JDX: begin
        mul_a = 32'(node_j);
        mul_b = $signed({1'b0, spacing_now});
      end
      OP_MUL_DRIFT: begin
        mul_a = decay_step;
        mul_b = xs;
      end
      OP_MUL_P: begin
        mul_a = off;
        mul_b = $signed({1'b0, recip_spacing_next});
      end
      OP_MUL_KD: begin
        mul_a = 32'(k);
        mul_b = $signed({1'b0, spacing_next});
      end
      OP_MUL_ETA: begin
        mul_a = eta;
        mul_b = $signed({1'b0, recip_spacing_next});
      end
      OP_MUL_SQ: begin
        mul_a = e;
        mul_b = e;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd_sum = prod + HALF24;
  assign kmag    = 17'(mag[63:48]) + 17'(mag[47:0] > 48'h8000_0000_0000);

  assign k_lo     = 12'(k) - 12'sd1;
  assign k_hi     = 12'(k) + 12'sd1;
  assign low_new  = (k_lo < range_low) ? k_lo : range_low;
  assign high_new = (k_hi > range_high) ? k_hi : range_high;

  assign s_up   = (48'(a) + 48'(e)) <<< 5;
  assign s_mid  = (ONE24 - 48'(a)) <<< 6;
  assign s_down = (48'(a) - 48'(e)) <<< 5;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value        <= '0;
      spacing_now        <= '0;
      spacing_next       <= '0;
      recip_spacing_next <= '0;
      decay_step         <= '0;
      variance_ratio     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_START_VALUE:    start_value        <= $signed(cfg_data);
        CFG_SPACING_NOW:    spacing_now        <= cfg_data[30:0];
        CFG_SPACING_NEXT:   spacing_next       <= cfg_data[30:0];
        CFG_RECIP_SPACING:  recip_spacing_next <= cfg_data[30:0];
        CFG_DECAY_STEP:     decay_step         <= $signed(cfg_data);
        CFG_VARIANCE_RATIO: variance_ratio     <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        node_j   <= node_index;
        last_reg <= last_node;
      end
      OP_MUL_JDX, OP_MUL_DRIFT, OP_MUL_P, OP_MUL_KD, OP_MUL_ETA, OP_MUL_SQ: begin
        prod <= mul_a * mul_b;
      end
      OP_X: begin
        jdx <= $signed(prod[41:0]);
        xs  <= sat32(48'($signed(prod[41:0])) + 48'(start_value));
      end
      OP_DRIFT: begin
        drift <= $signed(rnd_sum[63:24]);
      end
      OP_OFF: begin
        off <= sat32(48'(jdx) - 48'(drift));
      end
      OP_ABS: begin
        p_neg <= prod[63];
        mag   <= prod[63] ? 64'(-prod) : 64'(prod);
      end
      OP_K: begin
        if (p_neg) begin
          k <= (kmag > 17'(NODE_LIM)) ? 11'(-NODE_LIM) : 11'(0) - kmag[10:0];
        end else begin
          k <= (kmag > 17'(NODE_LIM - 1)) ? 11'(NODE_LIM - 1) : $signed(kmag[10:0]);
        end
      end
      OP_ETA: begin
        eta <= sat32(48'(off) - 48'($signed(prod[41:0])));
      end
      OP_E: begin
        e <= sat32(48'($signed(rnd_sum[63:24])));
      end
      OP_A: begin
        a <= 41'(variance_ratio) + $signed({1'b0, rnd_sum[63:24]});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      branch_centre <= k;
      prob_up       <= sat32(s_up);
      prob_mid      <= sat32(s_mid);
      prob_down     <= sat32(s_down);
      next_min      <= low_new;
      next_max      <= high_new;
      range_final   <= last_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      range_low  <= RANGE_LOW_INIT;
      range_high <= RANGE_HIGH_INIT;
    end else begin
      if (cmd.emit) begin
        out_valid  <= 1'b1;
        range_low  <= last_reg ? RANGE_LOW_INIT : low_new;
        range_high <= last_reg ? RANGE_HIGH_INIT : high_new;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over a pending item");

  a_range_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (next_min <= 12'(branch_centre) - 12'sd1)
               && (next_max >= 12'(branch_centre) + 12'sd1))
    else $error("reported range misses the centre node");

  a_range_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && last_reg) |=>
      (range_low == RANGE_LOW_INIT) && (range_high == RANGE_HIGH_INIT))
    else $error("range not restarted after last node");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tbp_pkg::*;

  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          SETTLE_TICKS = 24;
  localparam logic [2:0]  CFG_SPARE_A  = 3'd6;
  localparam logic [2:0]  CFG_SPARE_B  = 3'd7;

  typedef struct packed {
    logic signed [10:0] centre;
    logic signed [31:0] up;
    logic signed [31:0] mid;
    logic signed [31:0] down;
    logic signed [11:0] lo;
    logic signed [11:0] hi;
    logic               fin;
  } branch_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [10:0] node_index;
  logic               last_node;
  logic               out_valid;
  logic               out_ready;
  logic signed [10:0] branch_centre;
  logic signed [31:0] prob_up;
  logic signed [31:0] prob_mid;
  logic signed [31:0] prob_down;
  logic signed [11:0] next_min;
  logic signed [11:0] next_max;
  logic               range_final;

  logic signed [31:0] x0_q;
  logic [30:0]        dx_q;
  logic [30:0]        dx1_q;
  logic [30:0]        recip_q;
  logic signed [31:0] decay_q;
  logic [30:0]        var_q;
  logic signed [11:0] range_lo_q;
  logic signed [11:0] range_hi_q;

  branch_t expected_branches[$];
  int      errors = 0;
  int      cycles = 0;
  bit      quiet  = 1'b0;

  trinomial_branch_probabilities_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .node_index    (node_index),
    .last_node     (last_node),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .branch_centre (branch_centre),
    .prob_up       (prob_up),
    .prob_mid      (prob_mid),
    .prob_down     (prob_down),
    .next_min      (next_min),
    .next_max      (next_max),
    .range_final   (range_final)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint round_q24(input longint x);
    return (x + 64'sd8388608) >>> 24;
  endfunction

  function automatic branch_t predict_branch(input logic signed [10:0] j_in, input logic fin);
    branch_t r;
    longint  j, jdx, x, drift, off, p, mag, k, eta, e, e2, a;
    j     = longint'(j_in);
    jdx   = j * longint'(dx_q);
    x     = clamp32(longint'(x0_q) + jdx);
    drift = round_q24(longint'(decay_q) * x);
    off   = clamp32(jdx - drift);
    p     = off * longint'(recip_q);
    mag   = (p < 0) ? -p : p;
    k     = mag >>> 48;
    if ((mag & 64'sh0000_FFFF_FFFF_FFFF) > 64'sh0000_8000_0000_0000) k++;
    if (p < 0) k = -k;
    if (k > NODE_LIM - 1) k = NODE_LIM - 1;
    if (k < -NODE_LIM) k = -NODE_LIM;
    eta = clamp32(off - k * longint'(dx1_q));
    e   = clamp32(round_q24(eta * longint'(recip_q)));
    e2  = round_q24(e * e);
    a   = longint'(var_q) + e2;
    if (k - 1 < longint'(range_lo_q)) range_lo_q = 12'(k - 1);
    if (k + 1 > longint'(range_hi_q)) range_hi_q = 12'(k + 1);
    r.centre = 11'(k);
    r.up     = 32'(clamp32((a + e) * 32));
    r.mid    = 32'(clamp32((64'sd16777216 - a) * 64));
    r.down   = 32'(clamp32((a - e) * 32));
    r.lo     = range_lo_q;
    r.hi     = range_hi_q;
    r.fin    = fin;
    if (fin) begin
      range_lo_q = RANGE_LOW_INIT;
      range_hi_q = RANGE_HIGH_INIT;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    branch_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      if (expected_branches.size() == 0) begin
        $error("branch result with no item pending");
        errors++;
      end else begin
        want = expected_branches.pop_front();
        check_field("branch_centre", want.centre, branch_centre);
        check_field("prob_up", want.up, prob_up);
        check_field("prob_mid", want.mid, prob_mid);
        check_field("prob_down", want.down, prob_down);
        check_field("next_min", want.lo, next_min);
        check_field("next_max", want.hi, next_max);
        check_field("range_final", want.fin, range_final);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(99) < 3) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_node(input logic signed [10:0] j, input logic fin);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    node_index <= j;
    last_node  <= fin;
    do @(posedge clk); while (!in_ready);
    expected_branches.push_back(predict_branch(j, fin));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_branches.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_START_VALUE:    x0_q    = data;
      CFG_SPACING_NOW:    dx_q    = data[30:0];
      CFG_SPACING_NEXT:   dx1_q   = data[30:0];
      CFG_RECIP_SPACING:  recip_q = data[30:0];
      CFG_DECAY_STEP:     decay_q = data;
      CFG_VARIANCE_RATIO: var_q   = data[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_params(input logic [31:0] x0, input logic [31:0] dx,
                            input logic [31:0] dx1, input logic [31:0] recip,
                            input logic [31:0] decay, input logic [31:0] vr);
    drain();
    write_reg(CFG_START_VALUE, x0);
    write_reg(CFG_SPACING_NOW, dx);
    write_reg(CFG_SPACING_NEXT, dx1);
    write_reg(CFG_RECIP_SPACING, recip);
    write_reg(CFG_DECAY_STEP, decay);
    write_reg(CFG_VARIANCE_RATIO, vr);
  endtask

  function automatic logic [31:0] pick_reg_value();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // registers still at their reset values
  task automatic test_reset_config();
    send_node(11'sd5, 1'b0);
    send_node(-11'sd7, 1'b0);
    send_node(11'sd0, 1'b1);
  endtask

  // dX = 0.5, dX1 = 1: odd nodes land exactly on a half and round toward zero
  task automatic test_rounding_halves();
    set_params(32'd0, 32'h0080_0000, 32'h0100_0000, 32'h0100_0000, 32'd0, 32'h0055_5555);
    send_node(11'sd1, 1'b0);
    send_node(-11'sd1, 1'b0);
    send_node(11'sd3, 1'b0);
    send_node(-11'sd3, 1'b0);
    send_node(11'sd2, 1'b0);
    send_node(-11'sd5, 1'b1);
  endtask

  // saturation of the state, the centre and the probabilities; spare indexes
  task automatic test_field_extremes();
    set_params(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF);
    send_node(-11'sd1024, 1'b0);
    send_node(11'sd1023, 1'b0);
    send_node(11'sd0, 1'b0);
    send_node(-11'sd1, 1'b1);
    set_params(32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0);
    write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_B, 32'h1234_5678);
    send_node(11'sd1023, 1'b0);
    send_node(-11'sd1024, 1'b1);
    set_params(32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0100_0000);
    send_node(11'sd1, 1'b0);
    send_node(-11'sd1, 1'b0);
    send_node(11'sd0, 1'b1);
  endtask

  task automatic test_random_slices(input int n_items);
    int     sent;
    int     phase;
    int     w;
    int     centre;
    int     j;
    int     step;
    int     dx1;
    longint recip;
    sent  = 0;
    phase = 0;
    while (sent < n_items) begin
      quiet = (phase == 1);
      dx1   = $urandom_range(1 << 18, 1 << 26);
      recip = (64'sd1 <<< 48) / dx1;
      if ($urandom_range(1)) recip = recip + $urandom_range(0, 8) - 4;
      set_params($urandom_range(0, 1 << 26) - (1 << 25),
                 $urandom_range(dx1 / 2, dx1 * 2), dx1, 32'(recip),
                 $urandom_range(0, 1 << 23) - (1 << 22),
                 32'h0055_5555 + $urandom_range(0, 1 << 23) - (1 << 22));
      repeat ($urandom_range(2, 6)) begin
        w      = $urandom_range(0, 30);
        centre = ($urandom_range(3) == 0) ? $urandom_range(0, 1800) - 900 : 0;
        step   = $urandom_range(1) ? 1 : -1;
        j      = centre - step * w;
        repeat (2 * w + 1) begin
          send_node(11'(j), j == centre + step * w);
          j = j + step;
          sent++;
        end
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_noise(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      set_params(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                 pick_reg_value(), pick_reg_value(), pick_reg_value());
      if ($urandom_range(1)) write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
      repeat ($urandom_range(10, 50)) begin
        send_node(11'($urandom), $urandom_range(7) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = CFG_START_VALUE;
    cfg_data   = 32'd0;
    in_valid   = 1'b0;
    node_index = 11'sd0;
    last_node  = 1'b0;
    x0_q       = 32'sd0;
    dx_q       = 31'd0;
    dx1_q      = 31'd0;
    recip_q    = 31'd0;
    decay_q    = 32'sd0;
    var_q      = 31'd0;
    range_lo_q = RANGE_LOW_INIT;
    range_hi_q = RANGE_HIGH_INIT;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_rounding_halves();
    test_field_extremes();
    test_random_slices(1500);
    test_random_noise(300);
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
